// ===== sv/pcpd_pkg.sv =====
package pcpd_pkg;

  typedef enum logic [3:0] {
    PH_STM     = 4'd0,
    PH_WK      = 4'd1,
    PH_BK      = 4'd2,
    PH_CODE    = 4'd3,
    PH_COLOR   = 4'd4,
    PH_CASTLE  = 4'd5,
    PH_EPFLAG  = 4'd6,
    PH_EPSQ    = 4'd7,
    PH_HALF_LO = 4'd8,
    PH_FULL    = 4'd9,
    PH_HALF_HI = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PLACE   = 2'd0,
    KIND_TRAILER = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic [2:0] PT_KING = 3'd5;
  localparam logic [5:0] SQ_A8   = 6'd56;
  localparam logic [5:0] SQ_H1   = 6'd7;
  localparam int unsigned NUM_CODES = 5;
  // Piece codes as values with the first stream bit in bit 0: pawn, knight,
  // bishop, rook, queen.
  localparam logic [NUM_CODES-1:0][3:0] CODE_TAB =
    {4'b1001, 4'b0111, 4'b0101, 4'b0011, 4'b0001};

  localparam int unsigned MAX_RES    = 3;
  localparam int unsigned QDEPTH     = 8;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  nbits;
    logic [5:0]  part;
    logic [5:0]  scan;
    logic [5:0]  wk;
    logic [5:0]  bk;
    logic        stm;
    logic [3:0]  castle;
    logic        epv;
    logic [5:0]  epsq;
    logic [6:0]  half;
    logic [15:0] full;
    logic        err;
  } dstate_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  square;
    logic [2:0]  piece_class;
    logic        piece_color;
    logic        side_to_move;
    logic [3:0]  castling_rights;
    logic        ep_valid;
    logic [5:0]  ep_square;
    logic [6:0]  halfmove_clock;
    logic [15:0] fullmove_number;
    logic        last;
  } res_t;

  typedef struct packed {
    logic          emit;
    res_t          r;
    dstate_t       s;
  } step_t;

  // Up to three results produced by one byte, written to the queue together.
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } qwr_t;

  function automatic dstate_t st_reset();
    dstate_t s;
    s       = '0;
    s.phase = PH_STM;
    s.scan  = SQ_A8;
    return s;
  endfunction

  // Advance the scan to the next square that holds no king. Two kings can be
  // skipped at most, so three rounds always settle it.
  function automatic dstate_t settle(dstate_t s_in, logic step_first);
    dstate_t s;
    logic    step;
    logic    done;
    s    = s_in;
    step = step_first;
    done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!done && step) begin
        if (s.scan == SQ_H1) begin
          s.phase = PH_CASTLE;
          s.nbits = '0;
          done    = 1'b1;
        end else if (s.scan[2:0] == 3'd7) begin
          s.scan = s.scan - 6'd15;
        end else begin
          s.scan = s.scan + 6'd1;
        end
      end
      if (!done) begin
        if (s.scan != s.wk && s.scan != s.bk) begin
          done = 1'b1;
        end else begin
          step = 1'b1;
        end
      end
    end
    return s;
  endfunction

  function automatic step_t take_bit(dstate_t s_in, logic b);
    step_t      o;
    logic [3:0] n1;
    logic       found;
    logic [2:0] idx;
    o       = '0;
    o.s     = s_in;
    n1      = s_in.nbits + 4'd1;
    found   = 1'b0;
    idx     = '0;
    case (s_in.phase)
      PH_STM: begin
        o.s.stm   = b;
        o.s.phase = PH_WK;
        o.s.nbits = '0;
        o.s.part  = '0;
      end
      PH_WK, PH_BK: begin
        o.s.part  = s_in.part | (6'(b) << s_in.nbits);
        o.s.nbits = n1;
        if (n1 == 4'd6) begin
          o.emit          = 1'b1;
          o.r.kind        = KIND_PLACE;
          o.r.square      = o.s.part;
          o.r.piece_class = PT_KING;
          if (s_in.phase == PH_WK) begin
            o.s.wk          = o.s.part;
            o.r.piece_color = 1'b0;
            o.s.phase       = PH_BK;
            o.s.nbits       = '0;
            o.s.part        = '0;
          end else begin
            o.s.bk          = o.s.part;
            o.r.piece_color = 1'b1;
            o.s.phase       = PH_CODE;
            o.s.scan        = SQ_A8;
            o.s.nbits       = '0;
            o.s.part        = '0;
            o.s             = settle(o.s, 1'b0);
          end
        end
      end
      PH_CODE: begin
        o.s.part  = s_in.part | (6'(b) << s_in.nbits);
        o.s.nbits = n1;
        if (n1 == 4'd1 && o.s.part == 6'd0) begin
          o.s.nbits = '0;
          o.s       = settle(o.s, 1'b1);
        end else if (n1 >= 4'd4) begin
          for (int k = 0; k < NUM_CODES; k++) begin
            if (!found && o.s.part[3:0] == CODE_TAB[k]) begin
              found = 1'b1;
              idx   = 3'(k);
            end
          end
          if (found) begin
            o.s.part  = {3'b000, idx};
            o.s.phase = PH_COLOR;
          end else begin
            o.s.err = 1'b1;
          end
          o.s.nbits = '0;
        end
      end
      PH_COLOR: begin
        o.emit          = 1'b1;
        o.r.kind        = KIND_PLACE;
        o.r.square      = s_in.scan;
        o.r.piece_class = s_in.part[2:0];
        o.r.piece_color = b;
        o.s.part        = '0;
        o.s.phase       = PH_CODE;
        o.s.nbits       = '0;
        o.s             = settle(o.s, 1'b1);
      end
      PH_CASTLE: begin
        o.s.castle = s_in.castle | (4'(b) << s_in.nbits);
        o.s.nbits  = n1;
        if (n1 == 4'd4) begin
          o.s.nbits = '0;
          o.s.phase = PH_EPFLAG;
        end
      end
      PH_EPFLAG: begin
        o.s.epv   = b;
        o.s.phase = b ? PH_EPSQ : PH_HALF_LO;
        o.s.nbits = '0;
      end
      PH_EPSQ: begin
        o.s.epsq  = s_in.epsq | (6'(b) << s_in.nbits);
        o.s.nbits = n1;
        if (n1 == 4'd6) begin
          o.s.nbits = '0;
          o.s.phase = PH_HALF_LO;
        end
      end
      PH_HALF_LO: begin
        o.s.half  = s_in.half | (7'(b) << s_in.nbits);
        o.s.nbits = n1;
        if (n1 == 4'd6) begin
          o.s.nbits = '0;
          o.s.phase = PH_FULL;
        end
      end
      PH_FULL: begin
        // The bit counter wraps after sixteen bits, which ends the field.
        o.s.full  = s_in.full | (16'(b) << s_in.nbits);
        o.s.nbits = n1;
        if (n1 == 4'd0) begin
          o.s.phase = PH_HALF_HI;
        end
      end
      PH_HALF_HI: begin
        o.s.half[6] = s_in.half[6] | b;
        o.s.phase   = PH_DONE;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

endpackage

// ===== sv/pcpd_decode.sv =====
module pcpd_decode
  import pcpd_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       space_ok,
  output qwr_t       qwr
);

  localparam int unsigned BC_W = $clog2(RECORD_BYTES);

  logic            held;
  logic [7:0]      byte_q;
  dstate_t         st;
  dstate_t         st_next;
  logic [BC_W-1:0] byte_count;
  logic [BC_W-1:0] byte_count_next;
  logic            fire;
  qwr_t            wr;

  assign fire     = held && space_ok;
  assign in_ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
    end
  end

  // All eight bits of the held byte walk through the field decoder in one
  // pass; each bit can complete at most one placement.
  always_comb begin
    dstate_t s;
    step_t   stp;
    res_t    tr;
    s       = st;
    stp     = '0;
    tr      = '0;
    wr      = '0;
    for (int i = 0; i < 8; i++) begin
      if (!s.err && s.phase != PH_DONE) begin
        stp = take_bit(s, byte_q[i]);
        s   = stp.s;
        if (stp.emit && wr.cnt != 2'd3) begin
          wr.res[wr.cnt] = stp.r;
          wr.cnt         = wr.cnt + 2'd1;
        end
      end
    end
    st_next         = s;
    byte_count_next = byte_count + 1'b1;
    if (byte_count == BC_W'(RECORD_BYTES - 1)) begin
      tr.last = 1'b1;
      if (s.err || s.phase != PH_DONE) begin
        tr.kind = KIND_ERROR;
      end else begin
        tr.kind            = KIND_TRAILER;
        tr.side_to_move    = s.stm;
        tr.castling_rights = s.castle;
        tr.ep_valid        = s.epv;
        tr.ep_square       = s.epsq;
        tr.halfmove_clock  = s.half;
        tr.fullmove_number = s.full;
      end
      if (wr.cnt != 2'd3) begin
        wr.res[wr.cnt] = tr;
        wr.cnt         = wr.cnt + 2'd1;
      end
      st_next         = st_reset();
      byte_count_next = '0;
    end
    if (!fire) begin
      wr.cnt = 2'd0;
    end
  end

  assign qwr = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= st_reset();
      byte_count <= '0;
    end else if (fire) begin
      st         <= st_next;
      byte_count <= byte_count_next;
    end
  end

endmodule

// ===== sv/pcpd_outq.sv =====
module pcpd_outq
  import pcpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  qwr_t qwr,
  output logic space_ok,
  output logic out_valid,
  input  logic out_ready,
  output res_t head
);

  res_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem[rp];
  // Room for the largest burst one byte can produce.
  assign space_ok  = count <= (QPTR_W + 1)'(QDEPTH - MAX_RES);

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (2'(j) < qwr.cnt) begin
        mem[wp + QPTR_W'(j)] <= qwr.res[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + QPTR_W'(qwr.cnt);
      rp    <= rp + QPTR_W'(pop);
      count <= count + (QPTR_W + 1)'(qwr.cnt) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

// ===== sv/packed_chess_position_decoder.sv =====
// Packed chess position decoder.
// Input channel (in_valid/in_ready, data_byte): one byte of a packed position
// record per transfer, bit 0 first. Every RECORD_BYTES bytes form one record.
// Output channel (out_valid/out_ready): one result per transfer. Each king
// and each decoded piece gives a placement (kind 0); the record's last byte
// adds a trailer (kind 1) with the header fields, or a malformed-record
// result (kind 2) when a piece code is unknown or the record runs short.
// Both end results carry last = 1.
// A byte taken into the input register is decoded there, and its results are
// written into the result queue, from which the first of them can transfer.
// Throughput: one byte per cycle while the queue has room. A byte yields at
// most three results, and the output delivers one per cycle while out_ready is
// high; the byte in the input register waits while the eight-entry result queue
// has fewer than three free entries. When the receiver stalls, results collect
// in that queue and in_ready falls once it fills; nothing is dropped.
// Reset (rst, synchronous) empties the queue and the input register and
// returns the decoder to the start of a record.
module packed_chess_position_decoder
  import pcpd_pkg::*;
#(
  parameter int unsigned RECORD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [5:0]  square,
  output logic [2:0]  piece_class,
  output logic        piece_color,
  output logic        side_to_move,
  output logic [3:0]  castling_rights,
  output logic        ep_valid,
  output logic [5:0]  ep_square,
  output logic [6:0]  halfmove_clock,
  output logic [15:0] fullmove_number,
  output logic        last
);

  qwr_t qwr;
  logic space_ok;
  res_t head;

  pcpd_decode #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .data_byte(data_byte),
    .space_ok (space_ok),
    .qwr      (qwr)
  );

  pcpd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .qwr      (qwr),
    .space_ok (space_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign kind            = head.kind;
  assign square          = head.square;
  assign piece_class     = head.piece_class;
  assign piece_color     = head.piece_color;
  assign side_to_move    = head.side_to_move;
  assign castling_rights = head.castling_rights;
  assign ep_valid        = head.ep_valid;
  assign ep_square       = head.ep_square;
  assign halfmove_clock  = head.halfmove_clock;
  assign fullmove_number = head.fullmove_number;
  assign last            = head.last;

endmodule

// ===== sv/pcpd_checker.sv =====
module pcpd_checker
  import pcpd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [5:0]  square,
  input logic [2:0]  piece_class,
  input logic        piece_color,
  input logic        side_to_move,
  input logic [3:0]  castling_rights,
  input logic        ep_valid,
  input logic [5:0]  ep_square,
  input logic [6:0]  halfmove_clock,
  input logic [15:0] fullmove_number,
  input logic        last
);

  // A stalled result must hold until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(square)
      && $stable(piece_color) && $stable(side_to_move) && $stable(ep_square)
      && $stable(fullmove_number) && $stable(last))
    else $error("result changed while stalled");

  // Only the end-of-record results carry last.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind != KIND_PLACE)))
    else $error("last does not match result kind");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> square == 6'd0 && piece_class == 3'd0
      && castling_rights == 4'd0 && fullmove_number == 16'd0 && halfmove_clock == 7'd0)
    else $error("malformed-record result carries data");

  a_piece_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PLACE |-> piece_class <= PT_KING && !ep_valid)
    else $error("placement with bad piece type or trailer data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind packed_chess_position_decoder pcpd_checker u_pcpd_checker (.*);
